### hw/rtl/scale_weight_led_formatter_macros.svh
// Assertion macros used by the scale weight LED formatter RTL.
`ifndef SCALE_WEIGHT_LED_FORMATTER_MACROS_SVH
`define SCALE_WEIGHT_LED_FORMATTER_MACROS_SVH

`ifndef SYNTHESIS
// Clocked assertion, disabled while the asynchronous reset is asserted.
`define SWLF_ASSERT_AR(name, clk, rst_n, prop) \
	name: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
		else $error("assertion failed: %m");
// Clocked assertion that also holds through reset.
`define SWLF_ASSERT_CLK(name, clk, prop) \
	name: assert property (@(posedge clk) (prop)) \
		else $error("assertion failed: %m");
`else
`define SWLF_ASSERT_AR(name, clk, rst_n, prop)
`define SWLF_ASSERT_CLK(name, clk, prop)
`endif

`endif

### hw/rtl/swlf_pkg.sv
// Types, constants and helper functions of the scale weight LED formatter.
package swlf_pkg;

	localparam int unsigned NUM_GLYPHS = 5;
	localparam int unsigned NUM_DEC_STEPS = 4;

	typedef logic [4:0] glyph_t;
	typedef glyph_t [0:NUM_GLYPHS-1] glyph_row_t;

	localparam glyph_t BLANK_GLYPH = 5'd16;
	localparam glyph_t MINUS_GLYPH = 5'd17;
	localparam glyph_t F_GLYPH     = 5'h0f;

	// Largest magnitude shown for a negative weight.
	localparam logic [16:0] NEG_MAX = 17'd9999;

	// Decimal place weights, most significant first.
	localparam logic [16:0] DEC_WEIGHT [NUM_DEC_STEPS] = '{
		17'd10000, 17'd1000, 17'd100, 17'd10
	};

	localparam logic [7:0]  FIRST_INDEX_RST   = 8'd1;
	localparam logic [7:0]  LAST_INDEX_RST    = 8'd4;
	localparam logic [15:0] ERROR_CODE_RST    = 16'h8000;
	localparam logic [15:0] OVERLOAD_CODE_RST = 16'h7fff;

	typedef enum logic [1:0] {
		CFG_FIRST_INDEX   = 2'd0,
		CFG_LAST_INDEX    = 2'd1,
		CFG_ERROR_CODE    = 2'd2,
		CFG_OVERLOAD_CODE = 2'd3
	} cfg_reg_t;

	typedef struct packed {
		logic [7:0]         first_index;
		logic [7:0]         last_index;
		logic signed [15:0] error_code;
		logic signed [15:0] overload_code;
	} cfg_t;

	typedef struct packed {
		logic               advance;
		logic signed [15:0] weight;
	} item_t;

	typedef struct packed {
		logic [7:0] scale_index;
		glyph_t     glyph_one;
		glyph_t     glyph_two;
		glyph_t     glyph_three;
		glyph_t     glyph_four;
		glyph_t     glyph_five;
	} result_t;

	typedef struct packed {
		logic [3:0]  digit;
		logic [14:0] rem;
	} dec_step_t;

	// One decimal place: parallel compares against the multiples of the place weight.
	function automatic dec_step_t dec_step(input logic [14:0] rem, input logic [16:0] unit);
		dec_step_t r;
		r.digit = 4'd0;
		r.rem   = rem;
		for (int k = 1; k < 10; k++) begin
			if ({2'b00, rem} >= 17'(17'(k) * unit)) begin
				r.digit = 4'(k);
				r.rem   = 15'({2'b00, rem} - 17'(17'(k) * unit));
			end
		end
		return r;
	endfunction

endpackage

### hw/rtl/swlf_index.sv
// Scale index counter with wrap from last_index back to first_index.
`include "scale_weight_led_formatter_macros.svh"

module swlf_index (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            fire,
	input  logic            advance,
	input  swlf_pkg::cfg_t  cfg,
	output logic [7:0]      scale_index
);

	logic [7:0] cur_q;
	logic [7:0] stepped;

	always_comb begin
		if (cur_q >= cfg.last_index) begin
			stepped = cfg.first_index;
		end else begin
			stepped = cur_q + 8'd1;
		end
		scale_index = advance ? stepped : cur_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_q <= swlf_pkg::FIRST_INDEX_RST;
		end else if (fire) begin
			cur_q <= scale_index;
		end
	end

	`SWLF_ASSERT_AR(a_wrap, clk, arst_n, fire && advance && (cur_q >= cfg.last_index) |=> cur_q == $past(cfg.first_index))
	`SWLF_ASSERT_AR(a_inc, clk, arst_n, fire && advance && (cur_q < cfg.last_index) |=> cur_q == 8'($past(cur_q) + 8'd1))
	`SWLF_ASSERT_AR(a_hold, clk, arst_n, !(fire && advance) |=> $stable(cur_q))

endmodule

### hw/rtl/swlf_glyph.sv
// Weight to display glyphs: code checks, decimal conversion and blanking.
module swlf_glyph (
	input  logic signed [15:0]  weight,
	input  swlf_pkg::cfg_t      cfg,
	output swlf_pkg::glyph_row_t glyphs
);

	logic                      neg;
	logic [16:0]               mag_neg;
	logic [14:0]               value;
	logic [3:0]                digit [swlf_pkg::NUM_GLYPHS];
	logic [14:0]               rem [swlf_pkg::NUM_DEC_STEPS+1];
	logic [swlf_pkg::NUM_GLYPHS-2:0] lead_zero;
	swlf_pkg::dec_step_t       st [swlf_pkg::NUM_DEC_STEPS];
	swlf_pkg::glyph_row_t      num_glyphs;

	always_comb begin
		neg     = weight[15];
		mag_neg = 17'h10000 - {1'b0, weight};
		if (!neg) begin
			value = weight[14:0];
		end else if (mag_neg > swlf_pkg::NEG_MAX) begin
			value = swlf_pkg::NEG_MAX[14:0];
		end else begin
			value = mag_neg[14:0];
		end

		rem[0] = value;
		for (int i = 0; i < swlf_pkg::NUM_DEC_STEPS; i++) begin
			st[i]      = swlf_pkg::dec_step(rem[i], swlf_pkg::DEC_WEIGHT[i]);
			digit[i]   = st[i].digit;
			rem[i+1]   = st[i].rem;
		end
		digit[swlf_pkg::NUM_GLYPHS-1] = rem[swlf_pkg::NUM_DEC_STEPS][3:0];

		// A negative magnitude stays below 10000, so its top digit is zero and the
		// same blanking chain applies; the minus sits just before the first nonzero digit.
		lead_zero[0] = (digit[0] == 4'd0);
		for (int i = 1; i < swlf_pkg::NUM_GLYPHS - 1; i++) begin
			lead_zero[i] = lead_zero[i-1] && (digit[i] == 4'd0);
		end
		for (int i = 0; i < swlf_pkg::NUM_GLYPHS - 1; i++) begin
			if (!lead_zero[i]) begin
				num_glyphs[i] = {1'b0, digit[i]};
			end else if (neg && (digit[i+1] != 4'd0)) begin
				num_glyphs[i] = swlf_pkg::MINUS_GLYPH;
			end else begin
				num_glyphs[i] = swlf_pkg::BLANK_GLYPH;
			end
		end
		num_glyphs[swlf_pkg::NUM_GLYPHS-1] = {1'b0, digit[swlf_pkg::NUM_GLYPHS-1]};

		// Error test wins over overload when both codes match.
		if (weight == cfg.error_code) begin
			glyphs = {swlf_pkg::NUM_GLYPHS{swlf_pkg::F_GLYPH}};
		end else if (weight == cfg.overload_code) begin
			glyphs = {swlf_pkg::NUM_GLYPHS{swlf_pkg::MINUS_GLYPH}};
		end else begin
			glyphs = num_glyphs;
		end
	end

endmodule

### hw/rtl/scale_weight_led_formatter.sv
// Top level of the scale weight LED formatter: config registers and two-stage pipeline.
//
//  channel  | handshake                  | payload
//  ---------+----------------------------+-------------------------------------
//  item     | item_valid / item_ready    | item   (advance, weight)
//  result   | result_valid / result_ready| result (scale_index, glyph_one..five)
//  config   | cfg_valid / cfg_ready      | cfg_index, cfg_data
//
// One item per cycle sustained while result_ready stays high; result_valid rises once the
// item has passed the input register and the glyph logic and index step have fed the
// result register. A stalled result holds the result register and, once the input
// register is also full, drops item_ready. Reset clears both stage valid bits, sets
// the index to 1, loads the config registers' reset values; cfg_ready is always high.
module scale_weight_led_formatter (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               item_valid,
	output logic               item_ready,
	input  swlf_pkg::item_t    item,
	output logic               result_valid,
	input  logic               result_ready,
	output swlf_pkg::result_t  result,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  swlf_pkg::cfg_reg_t cfg_index,
	input  logic [15:0]        cfg_data
);

	swlf_pkg::cfg_t       cfg_q;
	logic                 v_s1;
	swlf_pkg::item_t      item_s1;
	logic                 v_s2;
	swlf_pkg::result_t    result_s2;
	logic                 adv_s1;
	logic                 fire;
	logic [7:0]           scale_index;
	swlf_pkg::glyph_row_t glyphs;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.first_index   <= swlf_pkg::FIRST_INDEX_RST;
			cfg_q.last_index    <= swlf_pkg::LAST_INDEX_RST;
			cfg_q.error_code    <= swlf_pkg::ERROR_CODE_RST;
			cfg_q.overload_code <= swlf_pkg::OVERLOAD_CODE_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				swlf_pkg::CFG_FIRST_INDEX:   cfg_q.first_index   <= cfg_data[7:0];
				swlf_pkg::CFG_LAST_INDEX:    cfg_q.last_index    <= cfg_data[7:0];
				swlf_pkg::CFG_ERROR_CODE:    cfg_q.error_code    <= cfg_data;
				swlf_pkg::CFG_OVERLOAD_CODE: cfg_q.overload_code <= cfg_data;
				default: ;
			endcase
		end
	end

	assign adv_s1     = !v_s2 || result_ready;
	assign item_ready = !v_s1 || adv_s1;
	assign fire       = v_s1 && adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (item_valid && item_ready) begin
			v_s1 <= 1'b1;
		end else if (adv_s1) begin
			v_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (item_valid && item_ready) begin
			item_s1 <= item;
		end
	end

	swlf_index u_index (
		.clk         (clk),
		.arst_n      (arst_n),
		.fire        (fire),
		.advance     (item_s1.advance),
		.cfg         (cfg_q),
		.scale_index (scale_index)
	);

	swlf_glyph u_glyph (
		.weight (item_s1.weight),
		.cfg    (cfg_q),
		.glyphs (glyphs)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (adv_s1) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			result_s2.scale_index <= scale_index;
			result_s2.glyph_one   <= glyphs[0];
			result_s2.glyph_two   <= glyphs[1];
			result_s2.glyph_three <= glyphs[2];
			result_s2.glyph_four  <= glyphs[3];
			result_s2.glyph_five  <= glyphs[4];
		end
	end

	assign result_valid = v_s2;
	assign result       = result_s2;

endmodule
